### rtl/core/text_console_writer_core_defines.svh
// Assertion macros used by the checker of the text console writer.
// No dependencies; include by bare file name.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that is also checked during reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer.
// No dependencies; used by every module of the block.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths fixed by the interface.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;
  localparam int ACT_W  = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [BYTE_W-1:0] BLANK_CHAR    = 8'h20;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR  = 8'h0A;
  localparam logic [BYTE_W-1:0] RETURN_CHAR   = 8'h0D;
  localparam logic [BYTE_W-1:0] RST_DEF_ATTR  = 8'd7;
  localparam logic [BYTE_W-1:0] RST_ESC_CODE  = 8'd27;

  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic REG_DEFAULT_ATTR = 1'b0;
  localparam logic REG_ESCAPE_CODE  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] default_attr;
    logic [BYTE_W-1:0] escape_code;
  } tcw_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]  cell_index;
    logic [BYTE_W-1:0] char_byte;
    logic [ACT_W-1:0]  action;
  } tcw_item_t;

  // Packed so that the last field, cursor_col, lands in the lowest bits.
  typedef struct packed {
    logic              attr_pending;
    logic [BYTE_W-1:0] read_attr;
    logic [BYTE_W-1:0] read_char;
    logic [POS_W-1:0]  cursor_pos;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } tcw_res_t;

  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic [POS_W-1:0]  raddr;
  } tcw_mem_req_t;

endpackage

`default_nettype wire

### rtl/core/tcw_screen_mem.sv
// Screen store: one write port and one registered read port.
// Depends on tcw_pkg.
`default_nettype none

module tcw_screen_mem (
  input  wire logic                      clk,
  input  wire tcw_pkg::tcw_mem_req_t     req,
  output logic [tcw_pkg::CELL_W-1:0]     rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/tcw_ctrl.sv
// Sequencer of the text console writer: cursor state, escape handling and the
// shared sweep counter that drives clear, scroll and the reset pass. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tcw_pkg::tcw_cfg_t        cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire tcw_pkg::tcw_item_t       in_item,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output tcw_pkg::tcw_res_t             res,
  output tcw_pkg::tcw_mem_req_t         mem_req,
  input  wire logic [tcw_pkg::CELL_W-1:0] mem_rdata
);
  import tcw_pkg::*;

  localparam logic [POS_W-1:0] LAST_CELL   = POS_W'(CELLS - 1);
  localparam logic [POS_W-1:0] SHIFT_CELLS = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] NUM_CELLS   = POS_W'(CELLS);
  localparam logic [POS_W-1:0] ROW_STRIDE  = POS_W'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(ROWS - 1);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDWAIT = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } tcw_state_t;

  tcw_state_t        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] attr_r, attr_nxt;
  logic              esc_r, esc_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] fill_attr_r, fill_attr_nxt;
  tcw_item_t         item_r, item_nxt;
  logic [BYTE_W-1:0] rchar_r, rchar_nxt;
  logic [BYTE_W-1:0] rattr_r, rattr_nxt;
  logic              newline;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pos_nxt       = pos_r;
    attr_nxt      = attr_r;
    esc_nxt       = esc_r;
    cnt_nxt       = cnt_r;
    fill_attr_nxt = fill_attr_r;
    item_nxt      = item_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    newline       = 1'b0;
    mem_req       = '0;

    case (state_r)
      ST_INIT, ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = {fill_attr_r, BLANK_CHAR};
        if (cnt_r == LAST_CELL) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + POS_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rchar_nxt = '0;
        rattr_nxt = '0;
        state_nxt = ST_DONE;
        case (item_r.action)
          ACT_PUT: begin
            if (esc_r) begin
              esc_nxt  = 1'b0;
              attr_nxt = item_r.char_byte;
            end else if (item_r.char_byte == cfg.escape_code) begin
              esc_nxt = 1'b1;
            end else if (item_r.char_byte inside {NEWLINE_CHAR, RETURN_CHAR}) begin
              newline = 1'b1;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = pos_r;
              mem_req.wdata = {attr_r, item_r.char_byte};
              if (col_r == COL_LAST) begin
                newline = 1'b1;
              end else begin
                col_nxt = col_r + COL_W'(1);
                pos_nxt = pos_r + POS_W'(1);
              end
            end
          end
          ACT_CLEAR: begin
            col_nxt       = '0;
            row_nxt       = '0;
            pos_nxt       = '0;
            cnt_nxt       = '0;
            fill_attr_nxt = cfg.default_attr;
            state_nxt     = ST_FILL;
          end
          ACT_READ: begin
            if (item_r.cell_index < NUM_CELLS) begin
              mem_req.raddr = item_r.cell_index;
              state_nxt     = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
        if (newline) begin
          col_nxt = '0;
          if (row_r == ROW_LAST) begin
            // Bottom row: the cursor stays on it and the screen moves up.
            pos_nxt       = SHIFT_CELLS;
            cnt_nxt       = '0;
            fill_attr_nxt = cfg.default_attr;
            state_nxt     = ST_SCROLL;
          end else begin
            row_nxt = row_r + ROW_W'(1);
            pos_nxt = pos_r - POS_W'(col_r) + ROW_STRIDE;
          end
        end
      end
      ST_RDWAIT: begin
        rchar_nxt = mem_rdata[BYTE_W-1:0];
        rattr_nxt = mem_rdata[CELL_W-1:BYTE_W];
        state_nxt = ST_DONE;
      end
      ST_SCROLL: begin
        // Read one row ahead and write the word read in the previous cycle.
        if (cnt_r < SHIFT_CELLS) begin
          mem_req.raddr = cnt_r + ROW_STRIDE;
        end
        if (cnt_r != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cnt_r - POS_W'(1);
          mem_req.wdata = mem_rdata;
        end
        if (cnt_r == SHIFT_CELLS) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + POS_W'(1);
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      pos_r       <= '0;
      attr_r      <= RST_DEF_ATTR;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      fill_attr_r <= RST_DEF_ATTR;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pos_r       <= pos_nxt;
      attr_r      <= attr_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      fill_attr_r <= fill_attr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    rchar_r <= rchar_nxt;
    rattr_r <= rattr_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res.cursor_col   = col_r;
    res.cursor_row   = row_r;
    res.cursor_pos   = pos_r;
    res.read_char    = rchar_r;
    res.read_attr    = rattr_r;
    res.attr_pending = esc_r;
  end

endmodule

`default_nettype wire

### rtl/core/text_console_writer_core.sv
// Channel   | Dir | Handshake              | Payload
// in_       | in  | in_tvalid / in_tready  | in_tdata: action, char_byte, cell_index
// out_      | out | out_tvalid / out_tready| out_tdata: cursor and read fields
// cfg_      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After reset the screen store is blanked by a pass over all COLUMNS*ROWS cells;
// no item is taken during it, configuration writes are.
// A put, an unused action or a read outside the screen passes from accept through
// ST_EXEC to ST_DONE, a read of a cell on the screen through ST_EXEC and ST_RDWAIT.
// Clear sweeps the whole store in ST_FILL; a newline on the bottom row moves the
// screen up in ST_SCROLL and blanks that row in ST_FILL, via the single port pair.
// The result sits in an output register, so a stalled result holds back only
// the completion of the next item. Depends on tcw_pkg, tcw_ctrl, tcw_screen_mem.
`default_nettype none

module text_console_writer_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // action [1:0], char_byte [9:2], cell_index [20:10], zero fill [23:21]
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // cursor_col [6:0], cursor_row [11:7], cursor_pos [22:12], read_char [30:23],
  // read_attr [38:31], attr_pending [39]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_index,
  input  wire logic [tcw_pkg::BYTE_W-1:0]         cfg_data
);
  import tcw_pkg::*;

  logic [BYTE_W-1:0] default_attr_r;
  logic [BYTE_W-1:0] escape_code_r;
  tcw_cfg_t          cfg;
  tcw_item_t         in_item;
  tcw_res_t          res;
  tcw_res_t          out_res_r;
  logic              out_valid_r;
  logic              res_valid;
  logic              res_ready;
  tcw_mem_req_t      mem_req;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= RST_DEF_ATTR;
      escape_code_r  <= RST_ESC_CODE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEFAULT_ATTR: default_attr_r <= cfg_data;
        REG_ESCAPE_CODE:  escape_code_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg.default_attr = default_attr_r;
  assign cfg.escape_code  = escape_code_r;

  assign in_item.action     = in_tdata[ACT_W-1:0];
  assign in_item.char_byte  = in_tdata[ACT_W+BYTE_W-1:ACT_W];
  assign in_item.cell_index = in_tdata[ACT_W+BYTE_W+POS_W-1:ACT_W+BYTE_W];

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tcw_screen_mem u_screen_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // The output register takes a new result once its current beat is gone.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_core_defines.svh.
`default_nettype none

`include "text_console_writer_core_defines.svh"

module tcw_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcw_pkg::*;

  `TCW_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid && !in_tready, "busy after reset")
  `TCW_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled beat changed")
  `TCW_ASSERT(a_cursor_range, clk, rst_n, out_tvalid |-> out_tdata[6:0] < COLUMNS && out_tdata[11:7] < ROWS, "cursor out of range")
  `TCW_ASSERT(a_pos_match, clk, rst_n, out_tvalid |-> out_tdata[22:12] == POS_W'(out_tdata[11:7] * COLUMNS + out_tdata[6:0]), "cursor position mismatch")
  `TCW_ASSERT(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second beat taken while busy")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);

`default_nettype wire
